// File: rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the selection range table: command codes,
// field widths, and the command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int LINE_BITS   = 20;
	localparam int COL_BITS    = 16;
	localparam int POS_BITS    = LINE_BITS + COL_BITS;
	localparam int ENTRY_BITS  = 2 * POS_BITS;
	localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int CMD_BITS    = 3;

	// Command codes carried on the cmd field
	typedef enum logic [CMD_BITS-1:0] {
		CMD_APPEND = 3'd0,
		CMD_UPDATE = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_QUERY  = 3'd4
	} cmd_t;

	// Table write source and address
	typedef enum logic [1:0] {
		WR_NONE   = 2'd0,
		WR_APPEND = 2'd1,
		WR_UPDATE = 2'd2,
		WR_SHIFT  = 2'd3
	} wr_op_t;

	// Table read address
	typedef enum logic [2:0] {
		RD_NONE = 3'd0,
		RD_PTR  = 3'd1,
		RD_PTR1 = 3'd2,
		RD_PTR2 = 3'd3,
		RD_LAST = 3'd4
	} rd_op_t;

	typedef enum logic [1:0] {
		PTR_HOLD = 2'd0,
		PTR_IDX  = 2'd1,
		PTR_ZERO = 2'd2,
		PTR_INC  = 2'd3
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2,
		CNT_CLR  = 2'd3
	} cnt_op_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		wr_op_t  wr_op;
		rd_op_t  rd_op;
		ptr_op_t ptr_op;
		cnt_op_t cnt_op;
		logic    set_err;
		logic    scan_en;
		logic    out_load;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic idx_ok;
		logic shift_more;
		logic scan_more;
	} stat_t;

endpackage

// File: rtl/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer for the range table: takes a word, steps the datapath through
// the command, fetches the newest range and hands the result word out.
// ----------------------------------------------------------------------------
module srt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  srt_pkg::stat_t stat,
	output srt_pkg::ctl_t  ctl
);

	typedef enum logic [7:0] {
		S_IDLE        = 8'b0000_0001,
		S_DECODE      = 8'b0000_0010,
		S_SHIFT_PRIME = 8'b0000_0100,
		S_SHIFT       = 8'b0000_1000,
		S_SCAN_PRIME  = 8'b0001_0000,
		S_SCAN        = 8'b0010_0000,
		S_FETCH       = 8'b0100_0000,
		S_OUT         = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.wr_op   = srt_pkg::WR_NONE;
		ctl.rd_op   = srt_pkg::RD_NONE;
		ctl.ptr_op  = srt_pkg::PTR_HOLD;
		ctl.cnt_op  = srt_pkg::CNT_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FETCH;
				unique case (stat.cmd)
					srt_pkg::CMD_APPEND: begin
						if (stat.full) begin
							ctl.set_err = 1'b1;
						end else begin
							ctl.wr_op  = srt_pkg::WR_APPEND;
							ctl.cnt_op = srt_pkg::CNT_INC;
						end
					end
					srt_pkg::CMD_UPDATE: begin
						if (stat.empty) begin
							ctl.set_err = 1'b1;
						end else begin
							ctl.wr_op = srt_pkg::WR_UPDATE;
						end
					end
					srt_pkg::CMD_REMOVE: begin
						if (stat.idx_ok) begin
							ctl.ptr_op = srt_pkg::PTR_IDX;
							state_d    = S_SHIFT_PRIME;
						end else begin
							ctl.set_err = 1'b1;
						end
					end
					srt_pkg::CMD_CLEAR: begin
						ctl.cnt_op = srt_pkg::CNT_CLR;
					end
					srt_pkg::CMD_QUERY: begin
						ctl.ptr_op = srt_pkg::PTR_ZERO;
						state_d    = S_SCAN_PRIME;
					end
					default: begin
						ctl.set_err = 1'b1;
					end
				endcase
			end
			S_SHIFT_PRIME: begin
				ctl.rd_op = srt_pkg::RD_PTR1;
				state_d   = S_SHIFT;
			end
			// Move each later entry down one place, one per cycle
			S_SHIFT: begin
				if (stat.shift_more) begin
					ctl.wr_op  = srt_pkg::WR_SHIFT;
					ctl.rd_op  = srt_pkg::RD_PTR2;
					ctl.ptr_op = srt_pkg::PTR_INC;
				end else begin
					ctl.cnt_op = srt_pkg::CNT_DEC;
					state_d    = S_FETCH;
				end
			end
			S_SCAN_PRIME: begin
				ctl.rd_op = srt_pkg::RD_PTR;
				state_d   = S_SCAN;
			end
			// Test one stored range per cycle against the query position
			S_SCAN: begin
				if (stat.scan_more) begin
					ctl.scan_en = 1'b1;
					ctl.rd_op   = srt_pkg::RD_PTR1;
					ctl.ptr_op  = srt_pkg::PTR_INC;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				ctl.rd_op = srt_pkg::RD_LAST;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/srt_dp.sv
// ----------------------------------------------------------------------------
// srt_dp
// Datapath: captured command word, range memory with one write and one
// registered read port, entry count, walk pointer, and the result registers.
// ----------------------------------------------------------------------------
module srt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srt_pkg::ctl_t                       ctl,
	output srt_pkg::stat_t                      stat,
	input  logic [srt_pkg::CMD_BITS-1:0]        cmd,
	input  logic [srt_pkg::LINE_BITS-1:0]       start_line,
	input  logic [srt_pkg::COL_BITS-1:0]        start_col,
	input  logic [srt_pkg::LINE_BITS-1:0]       end_line,
	input  logic [srt_pkg::COL_BITS-1:0]        end_col,
	input  logic [srt_pkg::ADDR_BITS-1:0]       entry_index,
	input  logic [srt_pkg::LINE_BITS-1:0]       query_line,
	input  logic [srt_pkg::COL_BITS-1:0]        query_col,
	output logic                                hit,
	output logic                                op_error,
	output logic [srt_pkg::CNT_BITS-1:0]        entry_count,
	output logic                                last_valid,
	output logic [srt_pkg::LINE_BITS-1:0]       last_start_line,
	output logic [srt_pkg::COL_BITS-1:0]        last_start_col,
	output logic [srt_pkg::LINE_BITS-1:0]       last_end_line,
	output logic [srt_pkg::COL_BITS-1:0]        last_end_col
);

	srt_pkg::cmd_t                        cmd_q;
	logic [srt_pkg::POS_BITS-1:0]         start_q, end_q, query_q;
	logic [srt_pkg::ADDR_BITS-1:0]        idx_q;
	logic [srt_pkg::CNT_BITS-1:0]         count_q, ptr_q;
	logic [srt_pkg::CNT_BITS-1:0]         cnt_m1, ptr_p1, ptr_p2;
	logic                                 hit_q, err_q;
	logic [srt_pkg::ENTRY_BITS-1:0]       mem_q [srt_pkg::MAX_ENTRIES];
	logic [srt_pkg::ENTRY_BITS-1:0]       rdata_q, wdata;
	logic [srt_pkg::ADDR_BITS-1:0]        waddr, raddr;
	logic                                 we, re;
	logic [srt_pkg::POS_BITS-1:0]         rd_start, rd_end;
	logic                                 match;

	assign cnt_m1 = count_q - srt_pkg::CNT_BITS'(1);
	assign ptr_p1 = ptr_q + srt_pkg::CNT_BITS'(1);
	assign ptr_p2 = ptr_q + srt_pkg::CNT_BITS'(2);

	// Status toward the controller
	assign stat.cmd        = cmd_q;
	assign stat.full       = (count_q >= srt_pkg::CNT_BITS'(srt_pkg::MAX_ENTRIES));
	assign stat.empty      = (count_q == '0);
	assign stat.idx_ok     = ({1'b0, idx_q} < count_q);
	assign stat.shift_more = (ptr_p1 < count_q);
	assign stat.scan_more  = (ptr_q < count_q);

	// Capture the command word
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= srt_pkg::cmd_t'(cmd);
			start_q <= {start_line, start_col};
			end_q   <= {end_line, end_col};
			idx_q   <= entry_index;
			query_q <= {query_line, query_col};
		end
	end

	// Pick memory addresses and write data
	always_comb begin
		we    = (ctl.wr_op != srt_pkg::WR_NONE);
		wdata = {start_q, end_q};
		unique case (ctl.wr_op)
			srt_pkg::WR_APPEND: waddr = count_q[srt_pkg::ADDR_BITS-1:0];
			srt_pkg::WR_UPDATE: waddr = cnt_m1[srt_pkg::ADDR_BITS-1:0];
			srt_pkg::WR_SHIFT: begin
				waddr = ptr_q[srt_pkg::ADDR_BITS-1:0];
				wdata = rdata_q;
			end
			default: waddr = '0;
		endcase
		re = (ctl.rd_op != srt_pkg::RD_NONE);
		unique case (ctl.rd_op)
			srt_pkg::RD_PTR:  raddr = ptr_q[srt_pkg::ADDR_BITS-1:0];
			srt_pkg::RD_PTR1: raddr = ptr_p1[srt_pkg::ADDR_BITS-1:0];
			srt_pkg::RD_PTR2: raddr = ptr_p2[srt_pkg::ADDR_BITS-1:0];
			srt_pkg::RD_LAST: raddr = cnt_m1[srt_pkg::ADDR_BITS-1:0];
			default:          raddr = '0;
		endcase
	end

	// Range memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Compare line first, then char: packed order does both at once
	assign rd_start = rdata_q[srt_pkg::ENTRY_BITS-1 -: srt_pkg::POS_BITS];
	assign rd_end   = rdata_q[srt_pkg::POS_BITS-1:0];
	assign match    = (query_q >= rd_start) && (query_q <= rd_end);

	// Count, walk pointer and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			hit_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (ctl.cnt_op)
				srt_pkg::CNT_INC: count_q <= count_q + srt_pkg::CNT_BITS'(1);
				srt_pkg::CNT_DEC: count_q <= cnt_m1;
				srt_pkg::CNT_CLR: count_q <= '0;
				default:          count_q <= count_q;
			endcase
			unique case (ctl.ptr_op)
				srt_pkg::PTR_IDX:  ptr_q <= {1'b0, idx_q};
				srt_pkg::PTR_ZERO: ptr_q <= '0;
				srt_pkg::PTR_INC:  ptr_q <= ptr_p1;
				default:           ptr_q <= ptr_q;
			endcase
			if (ctl.capture) begin
				hit_q <= 1'b0;
				err_q <= 1'b0;
			end else begin
				if (ctl.set_err) begin
					err_q <= 1'b1;
				end
				if (ctl.scan_en && stat.scan_more && match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Load the result word; newest range reads as zeros on an empty table
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			hit         <= hit_q;
			op_error    <= err_q;
			entry_count <= count_q;
			last_valid  <= !stat.empty;
			if (stat.empty) begin
				last_start_line <= '0;
				last_start_col  <= '0;
				last_end_line   <= '0;
				last_end_col    <= '0;
			end else begin
				last_start_line <= rd_start[srt_pkg::POS_BITS-1 -: srt_pkg::LINE_BITS];
				last_start_col  <= rd_start[srt_pkg::COL_BITS-1:0];
				last_end_line   <= rd_end[srt_pkg::POS_BITS-1 -: srt_pkg::LINE_BITS];
				last_end_col    <= rd_end[srt_pkg::COL_BITS-1:0];
			end
		end
	end

endmodule

// File: rtl/selection_range_table.sv
// ----------------------------------------------------------------------------
// selection_range_table
// Ordered table of up to sixteen inclusive text ranges with append, update,
// remove, clear and position query commands.
// ----------------------------------------------------------------------------
// One word is taken at a time. Append, update, clear and bad commands go
// from decode to a fetch of the newest range and then load the result word;
// a removal first shifts each later entry down one place and a query first
// tests each stored range, both through the range memory's one registered
// read port, walked one entry a cycle. The result is loaded once the output
// register is free, and the next word is taken the cycle after the result is
// loaded. A new word is taken while the previous result still waits for
// out_ready.
module selection_range_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [srt_pkg::CMD_BITS-1:0]  cmd,
	input  logic [srt_pkg::LINE_BITS-1:0] start_line,
	input  logic [srt_pkg::COL_BITS-1:0]  start_col,
	input  logic [srt_pkg::LINE_BITS-1:0] end_line,
	input  logic [srt_pkg::COL_BITS-1:0]  end_col,
	input  logic [srt_pkg::ADDR_BITS-1:0] entry_index,
	input  logic [srt_pkg::LINE_BITS-1:0] query_line,
	input  logic [srt_pkg::COL_BITS-1:0]  query_col,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          op_error,
	output logic [srt_pkg::CNT_BITS-1:0]  entry_count,
	output logic                          last_valid,
	output logic [srt_pkg::LINE_BITS-1:0] last_start_line,
	output logic [srt_pkg::COL_BITS-1:0]  last_start_col,
	output logic [srt_pkg::LINE_BITS-1:0] last_end_line,
	output logic [srt_pkg::COL_BITS-1:0]  last_end_col
);

	srt_pkg::ctl_t  ctl;
	srt_pkg::stat_t stat;

	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	srt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.cmd             (cmd),
		.start_line      (start_line),
		.start_col       (start_col),
		.end_line        (end_line),
		.end_col         (end_col),
		.entry_index     (entry_index),
		.query_line      (query_line),
		.query_col       (query_col),
		.hit             (hit),
		.op_error        (op_error),
		.entry_count     (entry_count),
		.last_valid      (last_valid),
		.last_start_line (last_start_line),
		.last_start_col  (last_start_col),
		.last_end_line   (last_end_line),
		.last_end_col    (last_end_col)
	);

	// Count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= srt_pkg::CNT_BITS'(srt_pkg::MAX_ENTRIES)))
		else $error("entry count above table depth");

	// Newest range is flagged exactly when the table holds something
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_valid == (entry_count != '0)))
		else $error("last_valid disagrees with entry count");

	// An ignored command never reports a hit
	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && op_error))
		else $error("hit reported on an ignored command");

	// One word in flight: no acceptance in the cycle after one
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word taken while busy");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the selection range table through idle and stall
// phases. A local model of the range table predicts each status word, and
// every returned status word is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Command codes the block does not define
	localparam logic [srt_pkg::CMD_BITS-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [srt_pkg::CMD_BITS-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [srt_pkg::CMD_BITS-1:0] CMD_SPARE_HI  = 3'd7;

	localparam int LINE_MAX = (1 << srt_pkg::LINE_BITS) - 1;
	localparam int COL_MAX  = (1 << srt_pkg::COL_BITS) - 1;

	typedef struct packed {
		logic [srt_pkg::CMD_BITS-1:0]  op;
		logic [srt_pkg::LINE_BITS-1:0] s_line;
		logic [srt_pkg::COL_BITS-1:0]  s_col;
		logic [srt_pkg::LINE_BITS-1:0] e_line;
		logic [srt_pkg::COL_BITS-1:0]  e_col;
		logic [srt_pkg::ADDR_BITS-1:0] idx;
		logic [srt_pkg::LINE_BITS-1:0] q_line;
		logic [srt_pkg::COL_BITS-1:0]  q_col;
	} edit_word_t;

	typedef struct packed {
		logic                          hit;
		logic                          err;
		logic [srt_pkg::CNT_BITS-1:0]  count;
		logic                          newest_ok;
		logic [srt_pkg::LINE_BITS-1:0] n_s_line;
		logic [srt_pkg::COL_BITS-1:0]  n_s_col;
		logic [srt_pkg::LINE_BITS-1:0] n_e_line;
		logic [srt_pkg::COL_BITS-1:0]  n_e_col;
	} table_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	edit_word_t cur_word = '0;

	logic                          hit;
	logic                          op_error;
	logic [srt_pkg::CNT_BITS-1:0]  entry_count;
	logic                          last_valid;
	logic [srt_pkg::LINE_BITS-1:0] last_start_line;
	logic [srt_pkg::COL_BITS-1:0]  last_start_col;
	logic [srt_pkg::LINE_BITS-1:0] last_end_line;
	logic [srt_pkg::COL_BITS-1:0]  last_end_col;

	edit_word_t    cmd_backlog[$];
	table_status_t due_status[$];
	int            mismatches = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int unsigned   gen_count = 0;

	// Local copy of the range table, positions packed as {line, col}
	logic [srt_pkg::POS_BITS-1:0] tbl_start[srt_pkg::MAX_ENTRIES];
	logic [srt_pkg::POS_BITS-1:0] tbl_end[srt_pkg::MAX_ENTRIES];
	int unsigned                  tbl_count = 0;

	selection_range_table u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cur_word.op),
		.start_line      (cur_word.s_line),
		.start_col       (cur_word.s_col),
		.end_line        (cur_word.e_line),
		.end_col         (cur_word.e_col),
		.entry_index     (cur_word.idx),
		.query_line      (cur_word.q_line),
		.query_col       (cur_word.q_col),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.hit             (hit),
		.op_error        (op_error),
		.entry_count     (entry_count),
		.last_valid      (last_valid),
		.last_start_line (last_start_line),
		.last_start_col  (last_start_col),
		.last_end_line   (last_end_line),
		.last_end_col    (last_end_col)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Apply one word to the local table and return the status it yields
	function automatic table_status_t apply_command(edit_word_t w);
		table_status_t s;
		logic [srt_pkg::POS_BITS-1:0] q;
		s = '0;
		q = {w.q_line, w.q_col};
		case (w.op)
			srt_pkg::CMD_APPEND: begin
				if (tbl_count >= srt_pkg::MAX_ENTRIES) begin
					s.err = 1'b1;
				end else begin
					tbl_start[srt_pkg::ADDR_BITS'(tbl_count)] = {w.s_line, w.s_col};
					tbl_end[srt_pkg::ADDR_BITS'(tbl_count)] = {w.e_line, w.e_col};
					tbl_count++;
				end
			end
			srt_pkg::CMD_UPDATE: begin
				if (tbl_count == 0) begin
					s.err = 1'b1;
				end else begin
					tbl_start[srt_pkg::ADDR_BITS'(tbl_count - 1)] = {w.s_line, w.s_col};
					tbl_end[srt_pkg::ADDR_BITS'(tbl_count - 1)] = {w.e_line, w.e_col};
				end
			end
			srt_pkg::CMD_REMOVE: begin
				if (int'(w.idx) >= int'(tbl_count)) begin
					s.err = 1'b1;
				end else begin
					for (int k = int'(w.idx); k + 1 < int'(tbl_count); k++) begin
						tbl_start[srt_pkg::ADDR_BITS'(k)] = tbl_start[srt_pkg::ADDR_BITS'(k + 1)];
						tbl_end[srt_pkg::ADDR_BITS'(k)] = tbl_end[srt_pkg::ADDR_BITS'(k + 1)];
					end
					tbl_count--;
				end
			end
			srt_pkg::CMD_CLEAR: tbl_count = 0;
			srt_pkg::CMD_QUERY: begin
				// inclusive on both ends; start after end matches nothing
				for (int k = 0; k < int'(tbl_count); k++)
					if (tbl_start[srt_pkg::ADDR_BITS'(k)] <= q &&
							q <= tbl_end[srt_pkg::ADDR_BITS'(k)])
						s.hit = 1'b1;
			end
			default: s.err = 1'b1;
		endcase
		s.count = tbl_count[srt_pkg::CNT_BITS-1:0];
		if (tbl_count > 0) begin
			s.newest_ok = 1'b1;
			{s.n_s_line, s.n_s_col} = tbl_start[srt_pkg::ADDR_BITS'(tbl_count - 1)];
			{s.n_e_line, s.n_e_col} = tbl_end[srt_pkg::ADDR_BITS'(tbl_count - 1)];
		end
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic edit_word_t make_word(logic [srt_pkg::CMD_BITS-1:0] op,
			int sl, int sc, int el, int ec, int idx, int ql, int qc);
		edit_word_t w;
		w = '{op, srt_pkg::LINE_BITS'(sl), srt_pkg::COL_BITS'(sc),
			srt_pkg::LINE_BITS'(el), srt_pkg::COL_BITS'(ec),
			srt_pkg::ADDR_BITS'(idx), srt_pkg::LINE_BITS'(ql),
			srt_pkg::COL_BITS'(qc)};
		return w;
	endfunction

	// Queue a word and track the fill level it leaves, to steer generation
	task automatic queue_word(edit_word_t w);
		case (w.op)
			srt_pkg::CMD_APPEND: if (gen_count < srt_pkg::MAX_ENTRIES) gen_count++;
			srt_pkg::CMD_REMOVE: if (int'(w.idx) < int'(gen_count)) gen_count--;
			srt_pkg::CMD_CLEAR:  gen_count = 0;
			default: ;
		endcase
		cmd_backlog = {cmd_backlog, w};
	endtask

	// Random word: mostly ranges and queries in a small neighborhood so that
	// hits and boundary cases are common, with full-width values mixed in
	function automatic edit_word_t rand_word();
		edit_word_t w;
		int r;
		int grow;
		logic [srt_pkg::LINE_BITS-1:0] base;
		w = edit_word_t'({$urandom, $urandom, $urandom, $urandom});
		grow = (gen_count >= srt_pkg::MAX_ENTRIES) ? 8 : (gen_count < 6 ? 45 : 28);
		r = $urandom_range(99);
		if (r < 3)
			w.op = CMD_SPARE_LO + srt_pkg::CMD_BITS'($urandom_range(2));
		else if (r < 5)
			w.op = srt_pkg::CMD_CLEAR;
		else if (r < 5 + grow)
			w.op = srt_pkg::CMD_APPEND;
		else if (r < 15 + grow)
			w.op = srt_pkg::CMD_UPDATE;
		else if (r < 32 + grow)
			w.op = srt_pkg::CMD_REMOVE;
		else
			w.op = srt_pkg::CMD_QUERY;
		if ($urandom_range(99) < 85) begin
			base = srt_pkg::LINE_BITS'($urandom_range(31));
			w.s_line = base;
			w.e_line = base + srt_pkg::LINE_BITS'($urandom_range(3));
			w.q_line = srt_pkg::LINE_BITS'($urandom_range(35));
			w.s_col = srt_pkg::COL_BITS'($urandom_range(15));
			w.e_col = srt_pkg::COL_BITS'($urandom_range(15));
			w.q_col = srt_pkg::COL_BITS'($urandom_range(15));
			// now and then move the start line past the end line so start lands after end
			if ($urandom_range(9) == 0) begin
				w.s_line = w.e_line + srt_pkg::LINE_BITS'(1);
			end
		end
		if (gen_count > 0 && $urandom_range(99) < 80)
			w.idx = srt_pkg::ADDR_BITS'($urandom_range(gen_count - 1));
		return w;
	endfunction

	// Drive: on acceptance predict the status, then present the next word
	always @(posedge clk or negedge arst_n) begin : drive
		edit_word_t pick;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cur_word <= '0;
		end else begin
			if (in_valid && in_ready)
				due_status = {due_status, apply_command(cur_word)};
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pick = cmd_backlog.pop_front();
					cur_word <= pick;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Watch the status side and compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		table_status_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_status.size() == 0) begin
					report_mismatch("status word with none expected");
				end else begin
					want = due_status.pop_front();
					check_field("hit", 32'(hit), 32'(want.hit));
					check_field("op_error", 32'(op_error), 32'(want.err));
					check_field("entry_count", 32'(entry_count), 32'(want.count));
					check_field("last_valid", 32'(last_valid), 32'(want.newest_ok));
					check_field("last_start_line", 32'(last_start_line),
						32'(want.n_s_line));
					check_field("last_start_col", 32'(last_start_col),
						32'(want.n_s_col));
					check_field("last_end_line", 32'(last_end_line),
						32'(want.n_e_line));
					check_field("last_end_col", 32'(last_end_col),
						32'(want.n_e_col));
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Hold off until every queued word is taken and every status is back
	task automatic drain();
		while (cmd_backlog.size() != 0 || in_valid || due_status.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Empty-table cases and unused codes
		queue_word(make_word(srt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_UPDATE, 1, 1, 2, 2, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(CMD_SPARE_HI, LINE_MAX, COL_MAX, LINE_MAX, COL_MAX,
			srt_pkg::MAX_ENTRIES - 1, LINE_MAX, COL_MAX));
		// Extremes of the position space
		queue_word(make_word(srt_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_APPEND, LINE_MAX, COL_MAX, LINE_MAX, COL_MAX,
			0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, LINE_MAX, COL_MAX));
		// Start after end matches nothing
		queue_word(make_word(srt_pkg::CMD_UPDATE, 9, 5, 3, 2, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 5, 0));
		// Multi-line range boundaries
		queue_word(make_word(srt_pkg::CMD_UPDATE, 2, 10, 4, 3, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 4, 3));
		queue_word(make_word(srt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 2, 9));
		// Fill the table, then overflow and remove at the edges
		for (int k = 0; k < srt_pkg::MAX_ENTRIES - 2; k++)
			queue_word(make_word(srt_pkg::CMD_APPEND, 2 * k, k, 2 * k + 1, COL_MAX,
				0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_APPEND, 7, 7, 8, 8, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_REMOVE, 0, 0, 0, 0, 15, 0, 0));
		queue_word(make_word(srt_pkg::CMD_REMOVE, 0, 0, 0, 0, 15, 0, 0));
		queue_word(make_word(srt_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(srt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));

		// Random traffic under each idle and stall mix
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 78; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 78; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			repeat (430) queue_word(rand_word());
			drain();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
